[hdl/wsfd_pkg.sv]
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types, constants and decode helpers for the weather sensor frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int FRAME_BYTES_DEF = 27;

  localparam logic [7:0] SYNC_RESET = 8'hD4;

  // configuration register indexes
  localparam logic REG_SYNC_VALUE = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNC     = 2'd1,
    ST_PARITY   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_req_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         station_id;
    logic signed [11:0] temperature_tenths;
    logic [7:0]         humidity_pct;
    logic [3:0]         wind_sector;
    logic [11:0]        gust_tenths;
    logic [10:0]        wind_avg_tenths;
    logic [10:0]        rain_tenths;
    logic               battery_good;
  } frame_result_t;

  function automatic logic [3:0] ones_in_byte(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // two nibbles of lo as ones and tens, low nibble of hi as hundreds
  function automatic logic [10:0] bcd3(input logic [7:0] lo, input logic [3:0] hi);
    return 11'(lo[3:0]) + 11'(lo[7:4]) * 11'd10 + 11'(hi) * 11'd100;
  endfunction

  function automatic logic [7:0] bcd2(input logic [7:0] v);
    return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
  endfunction

endpackage

[hdl/weather_sensor_frame_decoder.sv]
// ----------------------------------------------------------------------------
// weather_sensor_frame_decoder
// Checks and decodes one weather station radio frame, one byte per request.
// ----------------------------------------------------------------------------
// Takes one frame byte per unstalled clock: a sync byte, the check bytes, then
// the data bytes, each of which must be the bitwise inverse of its check byte.
// Every byte is handled in the cycle it is accepted, so a new byte can be taken
// on every unstalled clock; the rate is one byte per cycle, set by the single
// update of the check and field shift lines. The last byte of a frame pushes
// one result (status plus decoded fields, all zero on error) into a two-entry
// output buffer; input stalls only while both entries wait. frame_start
// restarts a frame and drops the partial one. sync_value sits at byte address 0.
module weather_sensor_frame_decoder #(
  parameter int FRAME_BYTES = wsfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  wsfd_pkg::byte_req_t     byte_req,
  output logic                    frame_valid,
  input  logic                    frame_stall,
  output wsfd_pkg::frame_result_t frame_result
);

  localparam int CHECK_COUNT = (FRAME_BYTES - 1) / 2;
  localparam int FIELD_COUNT = CHECK_COUNT - 1;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CHECK_LAST = POS_W'(CHECK_COUNT);
  localparam logic [POS_W-1:0] POS_DATA0      = POS_W'(CHECK_COUNT + 1);

  // configuration
  logic [7:0] sync_value;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= wsfd_pkg::SYNC_RESET;
    end else if (psel && penable && pwrite && paddr[2] == wsfd_pkg::REG_SYNC_VALUE) begin
      sync_value <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == wsfd_pkg::REG_SYNC_VALUE) begin
      prdata = {24'd0, sync_value};
    end
  end

  // frame state
  logic [POS_W-1:0] pos;
  logic [6:0]       ones_count;
  logic             sync_bad;
  logic             parity_bad;
  logic [7:0]       count_ref;
  logic [7:0]       chk [CHECK_COUNT];
  logic [7:0]       fld [FIELD_COUNT-1];

  logic             accept;
  logic             push;
  logic [POS_W-1:0] pos_cur;
  logic             is_check;
  logic             is_data;
  logic             is_field;
  logic             parity_next;
  logic [6:0]       ones_next;
  logic [7:0]       f [FIELD_COUNT];
  wsfd_pkg::frame_result_t res;

  logic                    v0, v1;
  wsfd_pkg::frame_result_t r0, r1;
  logic                    pop;

  assign byte_stall = v1;
  assign accept     = byte_valid && !byte_stall;
  assign pos_cur    = byte_req.frame_start ? '0 : pos;
  assign is_check   = (pos_cur != '0) && (pos_cur <= POS_CHECK_LAST);
  assign is_data    = pos_cur > POS_CHECK_LAST;
  assign is_field   = pos_cur > POS_DATA0;
  assign push       = accept && (pos_cur == POS_LAST);

  // while data bytes arrive, chk[0] is the check byte paired with the incoming data byte
  assign parity_next = parity_bad || ((chk[0] ^ byte_req.data_byte) != 8'hff);
  assign ones_next   = ones_count + 7'(wsfd_pkg::ones_in_byte(byte_req.data_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ones_count <= '0;
      sync_bad   <= 1'b0;
      parity_bad <= 1'b0;
    end else if (accept) begin
      pos <= (pos_cur == POS_LAST) ? '0 : pos_cur + 1'b1;
      if (pos_cur == '0) begin
        sync_bad   <= byte_req.data_byte != sync_value;
        parity_bad <= 1'b0;
        ones_count <= '0;
      end else if (is_data) begin
        parity_bad <= parity_next;
        if (is_field) begin
          ones_count <= ones_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (is_check || is_data)) begin
      for (int i = 0; i < CHECK_COUNT - 1; i++) begin
        chk[i] <= chk[i+1];
      end
      chk[CHECK_COUNT-1] <= byte_req.data_byte;
    end
    if (accept && pos_cur == POS_W'(1)) begin
      count_ref <= ~byte_req.data_byte;
    end
    if (accept && is_field) begin
      for (int i = 0; i < FIELD_COUNT - 2; i++) begin
        fld[i] <= fld[i+1];
      end
      fld[FIELD_COUNT-2] <= byte_req.data_byte;
    end
  end

  // field bytes of the frame, the last one straight from the request
  always_comb begin
    for (int i = 0; i < FIELD_COUNT - 1; i++) begin
      f[i] = fld[i];
    end
    f[FIELD_COUNT-1] = byte_req.data_byte;
  end

  always_comb begin
    logic [10:0]        t_mag;
    logic signed [11:0] t_s;
    t_mag = wsfd_pkg::bcd3(f[6], f[7][3:0]);
    t_s   = signed'({1'b0, t_mag});
    res   = '0;
    priority if (sync_bad) begin
      res.status = wsfd_pkg::ST_SYNC;
    end else if (parity_next) begin
      res.status = wsfd_pkg::ST_PARITY;
    end else if ({1'b0, ones_next} != count_ref) begin
      res.status = wsfd_pkg::ST_CHECKSUM;
    end else begin
      res.status             = wsfd_pkg::ST_OK;
      res.station_id         = f[0];
      res.temperature_tenths = (f[11][3:0] != 4'd0) ? -t_s : t_s;
      res.humidity_pct       = wsfd_pkg::bcd2(f[8]);
      res.wind_sector        = f[3][7:4];
      res.gust_tenths        = {f[3][3:0], f[2]};
      res.wind_avg_tenths    = wsfd_pkg::bcd3(f[4], f[5][3:0]);
      res.rain_tenths        = wsfd_pkg::bcd3(f[9], f[10][3:0]);
      res.battery_good       = !f[11][7];
    end
  end

  // two-entry result buffer, r0 is the head
  assign pop          = v0 && !frame_stall;
  assign frame_valid  = v0;
  assign frame_result = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        r0 <= r1;
        v0 <= 1'b1;
        v1 <= push;
        if (push) begin
          r1 <= res;
        end
      end else begin
        v0 <= push;
        r0 <= res;
      end
    end else if (push) begin
      if (!v0) begin
        r0 <= res;
        v0 <= 1'b1;
      end else begin
        r1 <= res;
        v1 <= 1'b1;
      end
    end
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst) v1 |-> v0)
    else $error("second result entry valid without head entry");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LAST)
    else $error("byte position beyond frame");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && !v0) |=> frame_valid)
    else $error("result of last byte not presented");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_result.status != wsfd_pkg::ST_OK) |->
      (frame_result.station_id == 8'd0 && frame_result.gust_tenths == 12'd0 &&
       frame_result.battery_good == 1'b0 && frame_result.rain_tenths == 11'd0))
    else $error("fields not cleared on error status");

  a_new_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && pos_cur == '0) |=> (ones_count == 7'd0 && !parity_bad))
    else $error("frame state not cleared at frame start");

endmodule
